### hw/rtl/qnorm_pkg.sv
// Shared types and constants for the half-precision quaternion normalizer.
// No dependencies.
`default_nettype none
package qnorm_pkg;

	// number of quaternion components
	localparam int unsigned NUM_COMP = 4;
	// binary16 fields
	localparam int unsigned HALF_W   = 16;
	localparam int unsigned EXP_W    = 5;
	localparam int unsigned MANT_W   = 10;
	localparam logic [EXP_W-1:0] EXP_NONFINITE = 5'h1F;
	// exact magnitude: 11-bit significand shifted left by at most 29
	localparam int unsigned MAG_SQ_W = 80;
	localparam int unsigned SUMSQ_W  = 83;
	// largest sum of squares (units of 2^-48) treated as a zero norm
	localparam logic [SUMSQ_W-1:0] TINY_SUMSQ = 83'd281;
	// output magnitude search width
	localparam int unsigned MAG_BITS = 15;
	localparam int unsigned UNIT_W   = 16;

	typedef enum logic [1:0] {
		FB_NORMAL    = 2'd0,
		FB_TINY      = 2'd1,
		FB_NONFINITE = 2'd2
	} fb_kind_t;

	// control that travels down the pipe with each word
	typedef struct packed {
		logic                nonfinite;
		fb_kind_t            kind;
		logic [NUM_COMP-1:0] neg;
	} qn_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/qnorm_front.sv
// Front end: binary16 decode, exact squares, sum of squares and search setup.
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_front #(
	parameter int unsigned OUT_FRAC_BITS = 15,
	parameter int unsigned W             = 120
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             en,
	input  wire logic                                             in_valid,
	input  wire logic [qnorm_pkg::NUM_COMP-1:0][qnorm_pkg::HALF_W-1:0] halves,
	output logic                                                  out_valid,
	output qnorm_pkg::qn_ctrl_t                                   out_ctrl,
	output logic [qnorm_pkg::SUMSQ_W-1:0]                         out_sumsq,
	output logic [qnorm_pkg::NUM_COMP-1:0][W-1:0]                 out_p,
	output logic [qnorm_pkg::NUM_COMP-1:0][W-1:0]                 out_rem
);

	localparam int unsigned NC = qnorm_pkg::NUM_COMP;
	localparam int unsigned SW = qnorm_pkg::SUMSQ_W;
	localparam int unsigned QW = qnorm_pkg::MAG_SQ_W;

	logic [4:1]                     v;
	qnorm_pkg::qn_ctrl_t            ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [NC-1:0][10:0]            mant_s1;
	logic [NC-1:0][4:0]             sh_s1, sh_s2, unused_sh;
	logic [NC-1:0][21:0]            prod_s2;
	logic [NC-1:0][QW-1:0]          sq_s3, sq_s4;
	logic [SW-1:0]                  sum_s4, sum_s5;
	logic [NC-1:0][W-1:0]           p_s5, rem_s5;
	logic                           valid_s5;
	logic                           nonfinite_d;

	assign unused_sh = '0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v        <= '0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			v        <= {v[3:1], in_valid};
			valid_s5 <= v[4];
		end
	end

	// any component with an all-ones exponent
	always_comb begin
		nonfinite_d = 1'b0;
		for (int i = 0; i < NC; i++)
			if (halves[i][14:10] == qnorm_pkg::EXP_NONFINITE)
				nonfinite_d = 1'b1;
	end

	// s1: field decode
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1.nonfinite <= nonfinite_d;
			ctrl_s1.kind      <= qnorm_pkg::FB_NORMAL;
			for (int i = 0; i < NC; i++) begin
				logic [4:0] e;
				e = halves[i][14:10];
				ctrl_s1.neg[i] <= halves[i][15];
				mant_s1[i]     <= {(e != 5'd0), halves[i][9:0]};
				sh_s1[i]       <= (e == 5'd0) ? 5'd0 : e - 5'd1;
			end
		end
	end

	// s2: significand squares
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2 <= ctrl_s1;
			for (int i = 0; i < NC; i++) begin
				prod_s2[i] <= mant_s1[i] * mant_s1[i];
				sh_s2[i]   <= sh_s1[i];
			end
		end
	end

	// s3: scale squares by twice the exponent
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s3 <= ctrl_s2;
			for (int i = 0; i < NC; i++)
				sq_s3[i] <= QW'(prod_s2[i]) << {sh_s2[i] | unused_sh[i], 1'b0};
		end
	end

	// s4: exact sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s4 <= ctrl_s3;
			sq_s4   <= sq_s3;
			sum_s4  <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]) + SW'(sq_s3[3]);
		end
	end

	// s5: fallback decision and residual setup, rem = 4c^2*2^2F - S, p = -S
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s5.nonfinite <= ctrl_s4.nonfinite;
			ctrl_s5.neg       <= ctrl_s4.neg;
			if (ctrl_s4.nonfinite)
				ctrl_s5.kind <= qnorm_pkg::FB_NONFINITE;
			else if (sum_s4 <= qnorm_pkg::TINY_SUMSQ)
				ctrl_s5.kind <= qnorm_pkg::FB_TINY;
			else
				ctrl_s5.kind <= qnorm_pkg::FB_NORMAL;
			sum_s5 <= sum_s4;
			for (int i = 0; i < NC; i++) begin
				rem_s5[i] <= (W'(sq_s4[i]) << (2 * OUT_FRAC_BITS + 2)) - W'(sum_s4);
				p_s5[i]   <= W'(0) - W'(sum_s4);
			end
		end
	end

	assign out_valid = valid_s5;
	assign out_ctrl  = ctrl_s5;
	assign out_sumsq = sum_s5;
	assign out_p     = p_s5;
	assign out_rem   = rem_s5;

endmodule
`default_nettype wire

### hw/rtl/qnorm_step.sv
// One bit of the rounded quotient search for all four lanes, one register stage.
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_step #(
	parameter int unsigned W   = 120,
	parameter int unsigned BIT = 14
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            en,
	input  wire logic                                            in_valid,
	input  wire qnorm_pkg::qn_ctrl_t                             in_ctrl,
	input  wire logic [qnorm_pkg::SUMSQ_W-1:0]                   in_sumsq,
	input  wire logic [qnorm_pkg::NUM_COMP-1:0][W-1:0]           in_p,
	input  wire logic [qnorm_pkg::NUM_COMP-1:0][W-1:0]           in_rem,
	input  wire logic [qnorm_pkg::NUM_COMP-1:0][qnorm_pkg::MAG_BITS-1:0] in_n,
	output logic                                                 out_valid,
	output qnorm_pkg::qn_ctrl_t                                  out_ctrl,
	output logic [qnorm_pkg::SUMSQ_W-1:0]                        out_sumsq,
	output logic [qnorm_pkg::NUM_COMP-1:0][W-1:0]                out_p,
	output logic [qnorm_pkg::NUM_COMP-1:0][W-1:0]                out_rem,
	output logic [qnorm_pkg::NUM_COMP-1:0][qnorm_pkg::MAG_BITS-1:0] out_n
);

	localparam int unsigned NC = qnorm_pkg::NUM_COMP;
	localparam int unsigned MB = qnorm_pkg::MAG_BITS;

	logic                    valid_s1;
	qnorm_pkg::qn_ctrl_t     ctrl_s1;
	logic [qnorm_pkg::SUMSQ_W-1:0] sum_s1;
	logic [NC-1:0][W-1:0]    p_s1, rem_s1;
	logic [NC-1:0][MB-1:0]   n_s1;
	logic signed [W-1:0]     s_wide;
	logic signed [NC-1:0][W-1:0] unused_tag;

	assign s_wide     = $signed(W'(in_sumsq));
	assign unused_tag = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	// with d = 2n-1 and P = d*S: raising n by 2^BIT grows d^2*S by
	// P*2^(BIT+2) + S*2^(2BIT+2); accept the bit when that fits in rem
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= in_ctrl;
			sum_s1  <= in_sumsq;
			for (int i = 0; i < NC; i++) begin
				logic signed [W-1:0] delta;
				delta = ($signed(in_p[i] | unused_tag[i]) <<< (BIT + 2))
				      + (s_wide <<< (2 * BIT + 2));
				if (delta <= $signed(in_rem[i])) begin
					rem_s1[i] <= W'($signed(in_rem[i]) - delta);
					p_s1[i]   <= W'($signed(in_p[i]) + (s_wide <<< (BIT + 1)));
					n_s1[i]   <= in_n[i] | MB'(1 << BIT);
				end else begin
					rem_s1[i] <= in_rem[i];
					p_s1[i]   <= in_p[i];
					n_s1[i]   <= in_n[i];
				end
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_ctrl  = ctrl_s1;
	assign out_sumsq = sum_s1;
	assign out_p     = p_s1;
	assign out_rem   = rem_s1;
	assign out_n     = n_s1;

endmodule
`default_nettype wire

### hw/rtl/fp16_quaternion_normalizer.sv
// Top level of the half-precision quaternion normalizer: front end, bit search
// chain and output register. Depends on qnorm_pkg, qnorm_front and qnorm_step.
`default_nettype none
// Normalizes a quaternion given as four binary16 words to signed fixed point
// with OUT_FRAC_BITS fraction bits, each component rounded to nearest (ties
// away from zero) from the exact quotient and saturated to +-32767. A near-zero
// norm (sum of squares at most 1e-12) or any infinite or NaN component yields
// the identity quaternion, flagged in m_tuser. The pipeline is 21 register
// stages deep: 5 front-end stages (decode, square, scale, sum, setup), one
// stage per output bit of the 15-bit quotient search, and the output register.
// A new word is accepted every cycle unless a finished word waits in the output
// register with m_tready low; then the whole pipe holds.
module fp16_quaternion_normalizer #(
	parameter int unsigned OUT_FRAC_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // w_half, x_half, y_half, z_half
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // w_unit, x_unit, y_unit, z_unit
	output logic [7:0]       m_tuser   // fallback_kind, zero fill
);

	localparam int unsigned NC  = qnorm_pkg::NUM_COMP;
	localparam int unsigned MB  = qnorm_pkg::MAG_BITS;
	localparam int unsigned UW  = qnorm_pkg::UNIT_W;
	localparam int unsigned RW0 = 2 * OUT_FRAC_BITS + 84;
	localparam int unsigned W   = ((RW0 > 117) ? RW0 : 117) + 2;
	localparam int unsigned ONE_W = (OUT_FRAC_BITS >= MB) ? ((1 << MB) - 1)
	                                                      : (1 << OUT_FRAC_BITS);
	localparam logic [UW-1:0] IDENT_W = UW'(ONE_W);

	logic                           en;
	logic [MB:0]                    c_valid;
	qnorm_pkg::qn_ctrl_t            c_ctrl  [MB+1];
	logic [qnorm_pkg::SUMSQ_W-1:0]  c_sum   [MB+1];
	logic [NC-1:0][W-1:0]           c_p     [MB+1];
	logic [NC-1:0][W-1:0]           c_rem   [MB+1];
	logic [NC-1:0][MB-1:0]          c_n     [MB+1];

	logic                           valid_s21;
	logic [NC-1:0][UW-1:0]          unit_s21;
	qnorm_pkg::fb_kind_t            kind_s21;

	// whole pipe advances unless a finished word is waiting
	assign en       = !valid_s21 || m_tready;
	assign s_tready = en;

	qnorm_front #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS),
		.W            (W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.halves   (s_tdata),
		.out_valid(c_valid[0]),
		.out_ctrl (c_ctrl[0]),
		.out_sumsq(c_sum[0]),
		.out_p    (c_p[0]),
		.out_rem  (c_rem[0])
	);
	assign c_n[0] = '0;

	// quotient bits, most significant first
	for (genvar k = 0; k < MB; k++) begin : g_step
		qnorm_step #(
			.W  (W),
			.BIT(MB - 1 - k)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (c_valid[k]),
			.in_ctrl  (c_ctrl[k]),
			.in_sumsq (c_sum[k]),
			.in_p     (c_p[k]),
			.in_rem   (c_rem[k]),
			.in_n     (c_n[k]),
			.out_valid(c_valid[k+1]),
			.out_ctrl (c_ctrl[k+1]),
			.out_sumsq(c_sum[k+1]),
			.out_p    (c_p[k+1]),
			.out_rem  (c_rem[k+1]),
			.out_n    (c_n[k+1])
		);
	end

	// output register: sign, fallback substitution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s21 <= 1'b0;
		else if (en)
			valid_s21 <= c_valid[MB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s21 <= c_ctrl[MB].kind;
			for (int i = 0; i < NC; i++) begin
				logic [UW-1:0] mag;
				mag = UW'(c_n[MB][i]);
				if (c_ctrl[MB].kind != qnorm_pkg::FB_NORMAL)
					unit_s21[i] <= (i == 0) ? IDENT_W : '0;
				else if (c_ctrl[MB].neg[i] && (mag != '0))
					unit_s21[i] <= UW'(0) - mag;
				else
					unit_s21[i] <= mag;
			end
		end
	end

	assign m_tvalid = valid_s21;
	assign m_tdata  = unit_s21;
	assign m_tuser  = {6'd0, kind_s21};

`ifndef SYNTHESIS
	// a fallback word is the identity
	a_fb_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != qnorm_pkg::FB_NORMAL) |->
			(m_tdata[63:16] == '0) && (m_tdata[15:0] == IDENT_W))
		else $error("fallback word is not the identity");
	// the most negative code is never produced
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000)
			&& (m_tdata[47:32] != 16'h8000) && (m_tdata[63:48] != 16'h8000))
		else $error("unit component is -32768");
	// nonfinite inputs always end as the nonfinite kind
	a_nonfinite_kind: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid[0] && c_ctrl[0].nonfinite |-> c_ctrl[0].kind == qnorm_pkg::FB_NONFINITE)
		else $error("nonfinite word lost its flag");
	// a stall freezes the search chain
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(c_valid))
		else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

### bench/tb_fp16_quaternion_normalizer.sv
// Self-checking bench for fp16_quaternion_normalizer: exact integer predictor,
// scoreboard class, random stall and gap injection. Depends on qnorm_pkg and the RTL.
`default_nettype none
module tb_fp16_quaternion_normalizer;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0]         unit [4];
		qnorm_pkg::fb_kind_t kind;
	} unit_quat_t;

	// exact magnitude of a finite half in units of 2^-24
	function automatic logic [40:0] half_to_fixed(logic [15:0] h);
		logic [4:0] e;
		logic [40:0] m;
		e = h[14:10];
		m = {31'd0, h[9:0]};
		if (e == 5'd0)
			return m;
		return (m + 41'd1024) << (e - 5'd1);
	endfunction

	// unit quaternion for one word of four halves
	function automatic unit_quat_t normalize_quat(logic [63:0] d);
		unit_quat_t r;
		logic [40:0]  mag [4];
		logic [127:0] sumsq, rhs, lhs, dd;
		logic [15:0]  h, n, t;
		for (int i = 0; i < 4; i++)
			r.unit[i] = 16'd0;
		r.unit[0] = 16'd32767;
		// any infinity or NaN wins over everything else
		for (int i = 0; i < 4; i++) begin
			if (d[16*i+10 +: 5] == qnorm_pkg::EXP_NONFINITE) begin
				r.kind = qnorm_pkg::FB_NONFINITE;
				return r;
			end
		end
		sumsq = '0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = half_to_fixed(d[16*i +: 16]);
			sumsq += 128'(mag[i]) * 128'(mag[i]);
		end
		if (sumsq <= 128'(qnorm_pkg::TINY_SUMSQ)) begin
			r.kind = qnorm_pkg::FB_TINY;
			return r;
		end
		// largest n with (2n-1)^2 * S <= c^2 * 2^(2F+2)
		for (int i = 0; i < 4; i++) begin
			h = d[16*i +: 16];
			rhs = (128'(mag[i]) * 128'(mag[i])) << 32;
			n = 16'd0;
			for (int b = 14; b >= 0; b--) begin
				t = n | (16'd1 << b);
				dd = 128'(2 * t - 1);
				lhs = dd * dd * sumsq;
				if (lhs <= rhs)
					n = t;
			end
			r.unit[i] = (h[15] && n != 0) ? -n : n;
		end
		r.kind = qnorm_pkg::FB_NORMAL;
		return r;
	endfunction

	class quat_scoreboard;
		unit_quat_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_input(logic [63:0] d);
			pending.push_back(normalize_quat(d));
		endfunction

		function void check_result(logic [63:0] d, logic [7:0] u);
			unit_quat_t e;
			bit bad;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h kind %0d", d, u[1:0]);
				return;
			end
			e = pending.pop_front();
			bad = (u[1:0] != e.kind);
			for (int i = 0; i < 4; i++)
				if (d[16*i +: 16] != e.unit[i])
					bad = 1;
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %h %h %h %h kind %0d, got %h kind %0d",
						e.unit[3], e.unit[2], e.unit[1], e.unit[0], e.kind, d, u[1:0]);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;
	logic [7:0]  m_tuser;

	quat_scoreboard sb = new();
	bit steady;          // no idling on either side
	int hold_cycles;     // long output stall requested by the stimulus

	fp16_quaternion_normalizer dut (.*);

	always #10 clk = ~clk;

	// watchdog
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// output side: check words, stall at random or for a requested stretch
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else
				m_tready <= steady || ($urandom_range(99) >= 11);
		end
	end

	task automatic send_word(logic [63:0] d);
		if (!steady && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_input(d);
	endtask

	task automatic send_quat(logic [15:0] w, x, y, z);
		send_word({z, y, x, w});
	endtask

	// random half, always finite, with exponents clustered around a base
	function automatic logic [15:0] rand_half(int base);
		logic [15:0] h;
		int e;
		h = 16'($urandom);
		e = base + $urandom_range(0, 6) - 3;
		if (e < 0) e = 0;
		if (e > 30) e = 30;
		h[14:10] = 5'(e);
		return h;
	endfunction

	initial begin
		int base, k;
		hold_cycles = 0;
		steady = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h3C00, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'hBC00, 16'h8000, 16'h0000, 16'h8000);
		send_quat(16'h0000, 16'hBC00, 16'h0000, 16'h0000);
		send_quat(16'h7BFF, 16'h7BFF, 16'h7BFF, 16'h7BFF);
		send_quat(16'hFBFF, 16'h7BFF, 16'hFBFF, 16'h0001);
		send_quat(16'h3800, 16'h3800, 16'h3800, 16'h3800);
		send_quat(16'h7C00, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h3C00, 16'hFC00, 16'h0000, 16'h0000);
		send_quat(16'h3C00, 16'h0000, 16'h7E00, 16'h0000);
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		// sum of squares right at the tiny threshold, and just above it
		send_quat(16'h0010, 16'h0005, 16'h0000, 16'h0000);
		send_quat(16'h0010, 16'h8006, 16'h0000, 16'h0000);
		send_quat(16'h0011, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h03FF, 16'h83FF, 16'h03FF, 16'h83FF);
		send_quat(16'h7BFF, 16'h0001, 16'h8001, 16'h0000);
		send_quat(16'h3C00, 16'h3C00, 16'h0000, 16'h0000);
		send_quat(16'h4000, 16'h3C00, 16'hBC00, 16'h3800);

		// random part with pressure phases
		for (int i = 0; i < 1450; i++) begin
			if (i == 300)
				steady = 1;
			if (i == 450)
				steady = 0;
			if (i == 600)
				hold_cycles = 150;
			if (i == 900) begin
				s_tvalid <= 1'b0;
				wait (sb.pending.size() == 0);
				@(posedge clk);
			end
			k = $urandom_range(99);
			if (k < 10)
				send_word({$urandom, $urandom});
			else if (k < 15)
				send_quat(16'($urandom_range(0, 31)) | 16'($urandom_range(0, 1) << 15),
					16'($urandom_range(0, 31)), 16'($urandom_range(0, 15)),
					16'($urandom_range(0, 1) << 15));
			else begin
				base = $urandom_range(0, 30);
				send_quat(rand_half(base), rand_half(base), rand_half(base),
					($urandom_range(9) == 0) ? 16'h0000 : rand_half(base));
			end
		end
		s_tvalid <= 1'b0;

		wait (sb.pending.size() == 0);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/qnorm_pkg.sv
hw/rtl/qnorm_front.sv
hw/rtl/qnorm_step.sv
hw/rtl/fp16_quaternion_normalizer.sv
bench/tb_fp16_quaternion_normalizer.sv
